// File: hw/rtl/vdt_pkg.sv
// ----------------------------------------------------------------------------
// vdt_pkg: shared types for the vertex deduplication table
// Request and response words, request codes, controller states and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vdt_pkg;

	// Request codes
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_MARK   = 2'd2;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned VERT_W  = 3 * COORD_W;
	localparam int unsigned OUT_IW  = 12;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [COORD_W-1:0] vert_x;
		logic [COORD_W-1:0] vert_y;
		logic [COORD_W-1:0] vert_z;
	} req_word_t;

	typedef struct packed {
		logic [OUT_IW-1:0] entry_index;
		logic              found;
		logic              store_full;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPEND,
		ST_EMIT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture request, rewind scan pointer
		logic mark;      // search base takes the entry count
		logic scan;      // issue one store read
		logic append;    // write request at the entry count
		logic res_hit;   // result is the matching entry
		logic res_full;  // result is a full flag
		logic res_zero;  // result is all zero
		logic emit;      // move result to the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic match;     // read entry equals the request triple
		logic scan_end;  // all entries read, none outstanding
		logic full;      // store holds DEPTH entries
		logic out_free;  // output register can take a word
	} dp_status_t;

endpackage

// File: hw/rtl/vdt_ctrl.sv
// ----------------------------------------------------------------------------
// vdt_ctrl: request sequencer
// Accepts one request at a time, steps the datapath through the scan,
// the append and the hand-off of the response word.
// ----------------------------------------------------------------------------
module vdt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          req_type,
	input  vdt_pkg::dp_status_t status,
	output vdt_pkg::dp_cmd_t    cmd
);
	import vdt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != ST_IDLE);

	// Advance the sequence and drive datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (req_type)
						REQ_LOOKUP: state_nxt = ST_SCAN;
						REQ_APPEND: state_nxt = ST_APPEND;
						REQ_MARK: begin
							cmd.mark     = 1'b1;
							cmd.res_zero = 1'b1;
							state_nxt    = ST_EMIT;
						end
						default: begin
							cmd.res_zero = 1'b1;
							state_nxt    = ST_EMIT;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.match) begin
					cmd.res_hit = 1'b1;
					state_nxt   = ST_EMIT;
				end else if (status.scan_end) begin
					state_nxt = ST_APPEND;
				end
			end
			ST_APPEND: begin
				if (status.full) begin
					cmd.res_full = 1'b1;
				end else begin
					cmd.append = 1'b1;
				end
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// File: hw/rtl/vdt_datapath.sv
// ----------------------------------------------------------------------------
// vdt_datapath: vertex store, scan pipeline and response register
// Holds the entry count, search base and scan pointer, reads one entry per
// cycle with registered read data, and keeps the outgoing response word.
// ----------------------------------------------------------------------------
module vdt_datapath #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vdt_pkg::req_word_t  req_word,
	input  vdt_pkg::dp_cmd_t    cmd,
	output vdt_pkg::dp_status_t status,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output vdt_pkg::rsp_word_t  rsp_word
);
	import vdt_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [VERT_W-1:0] mem [DEPTH];

	logic [VERT_W-1:0] vert_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     base_q;
	logic [CW-1:0]     ptr_q;
	logic              rd_vld_q;
	logic [IW-1:0]     rd_idx_q;
	logic [VERT_W-1:0] rd_data_q;
	logic [IW-1:0]     res_idx_q;
	logic              res_found_q;
	logic              res_full_q;
	logic              out_vld_q;
	rsp_word_t         out_q;

	logic rd_en;
	logic wr_en;

	assign rd_en = cmd.scan && (ptr_q < count_q);
	assign wr_en = cmd.append;

	// Capture the request triple
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vert_q <= {req_word.vert_x, req_word.vert_y, req_word.vert_z};
		end
	end

	// Store write at the entry count, registered read at the scan pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= vert_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[ptr_q[IW-1:0]];
		end
	end

	// Track count, base, scan pointer and read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			base_q   <= '0;
			ptr_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.mark) begin
				base_q <= count_q;
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.load) begin
				ptr_q    <= base_q;
				rd_vld_q <= 1'b0;
			end else begin
				rd_vld_q <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
		end
	end

	// Remember which entry the read data belongs to
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_q <= ptr_q[IW-1:0];
		end
	end

	// Build the pending response
	always_ff @(posedge clk) begin
		if (cmd.res_hit) begin
			res_idx_q   <= rd_idx_q;
			res_found_q <= 1'b1;
			res_full_q  <= 1'b0;
		end else if (cmd.res_full) begin
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b1;
		end else if (cmd.append) begin
			res_idx_q   <= count_q[IW-1:0];
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else if (cmd.res_zero) begin
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
		end
	end

	// Output register: drop the word once taken, load a new one when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.entry_index <= OUT_IW'(res_idx_q);
			out_q.found       <= res_found_q;
			out_q.store_full  <= res_full_q;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp_word  = out_q;

	assign status.match    = rd_vld_q && (rd_data_q == vert_q);
	assign status.scan_end = !rd_vld_q && (ptr_q >= count_q);
	assign status.full     = (count_q == CW'(DEPTH));
	assign status.out_free = !out_vld_q || !rsp_stall;

endmodule

// File: hw/rtl/vertex_dedup_table.sv
// ----------------------------------------------------------------------------
// vertex_dedup_table: exact-match vertex deduplication store
// Usage:
//   Request channel (req_valid/req_stall/req_word) takes one word at a time.
//   req_stall is high from the cycle after a word is accepted until its
//   response has been loaded into the output register.
//   A lookup reads the store one entry per cycle from the search base up to
//   the entry count, lowest index first, and stops at the first match; a
//   miss appends the triple. A forced append skips the scan. A mark request
//   moves the search base to the entry count.
//   Mark and unused codes go straight to an all-zero response; an append
//   writes the triple, or flags a full store, and then responds; a lookup
//   reads its entries one at a time through the single read port of the
//   store, so it takes longer the more entries it searches. The next word
//   is taken only after the last response is loaded into the output register.
//   Response channel (rsp_valid/rsp_stall/rsp_word) is driven from an output
//   register; while it is stalled the word holds and the next request can
//   still be accepted and worked on, waiting only to hand its response over.
//   Reset clears the entry count, search base and all handshake state; the
//   store contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module vertex_dedup_table #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  vdt_pkg::req_word_t req_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output vdt_pkg::rsp_word_t rsp_word
);
	import vdt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequence requests
	vdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_word.req_type),
		.status    (status),
		.cmd       (cmd)
	);

	// Store, scan and response
	vdt_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule

// File: hw/rtl/vdt_checker.sv
// ----------------------------------------------------------------------------
// vdt_checker: port-level checks for the vertex deduplication table
// Watches the request and response channels and flags inconsistent words.
// ----------------------------------------------------------------------------
module vdt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input vdt_pkg::rsp_word_t rsp_word
);
	import vdt_pkg::*;

	// Stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("response word changed while stalled");

	// One request in flight: stall rises right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	// A hit never reports a full store
	a_hit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_word.found && rsp_word.store_full))
		else $error("found and store_full both set");

	// A full store reports index zero
	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.store_full |-> rsp_word.entry_index == '0)
		else $error("nonzero index with store_full");

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);
